// ===== rtl/iarr_pkg.sv =====
// operation and status codes shared by the packed list unit
// no dependencies
`default_nettype none

package iarr_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // fixed port widths of the request and response words
   localparam int POS_W   = 4;
   localparam int FPOS_W  = 3;
   localparam int COUNT_W = 4;
   localparam int REQ_VALUE_W = 32;

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] status_type;

endpackage

`default_nettype wire

// ===== rtl/iarr_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module iarr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/indexed_array_insert_remove_find_unit.sv =====
// top level of the packed list unit: control sequencer around one entry ram
// depends on iarr_pkg and iarr_ram
//
// request channel req_*: opcode, position, value; a word is taken at a clock
//   edge with req_valid high and req_stall low
// response channel rsp_*: status, found, found_position, entry_count; one
//   response word per request, in request order, held while rsp_stall is high
// insert moves entries up one at a time, remove moves them down, find scans
//   from position 0 and stops at the first match
// work: one request in work at a time, each moved or compared entry costs
//   one ram read; a rejected or unused opcode goes straight to the response
// reset: synchronous, active high; clears the entry count and the handshake
//   state, ram contents are left as they are (only written entries are read)
// stall: the next request is taken while a response waits; if the following
//   response is ready while one is still stalled, the sequencer holds in its
//   final step and takes no further request until the waiting word is taken
`default_nettype none

module indexed_array_insert_remove_find_unit
   import iarr_pkg::*;
#(
   parameter int DEPTH       = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [REQ_VALUE_W-1:0] req_value,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_found,
   output logic [FPOS_W-1:0]             rsp_found_position,
   output logic [COUNT_W-1:0]            rsp_entry_count
);

   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = CNT_W > POS_W ? CNT_W : POS_W;
   localparam int OUTC_W = CNT_W > COUNT_W ? CNT_W : COUNT_W;
   localparam int OUTP_W = ADDR_W > FPOS_W ? ADDR_W : FPOS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REMOVE,
      S_SEARCH,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   opcode_type          op_ff, op_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   status_type          status_ff, status_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cnt_new_ff, cnt_new_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   tag_ff, tag_in;
   logic                hit_ff, hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [FPOS_W-1:0]   rsp_fpos_ff, rsp_fpos_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // ram ports
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   logic [VALUE_WIDTH-1:0] req_val_w;
   logic [CMP_W-1:0]    cmp_pos, cmp_cnt;
   logic [CNT_W-1:0]    ptr_plus, ptr_minus;
   logic [OUTC_W-1:0]   count_wide;
   logic [OUTP_W-1:0]   fpos_wide;

   // value is kept in its low VALUE_WIDTH bits, zero extended when wider
   generate
      if (VALUE_WIDTH <= REQ_VALUE_W) begin : g_val_trunc
         assign req_val_w = req_value[VALUE_WIDTH-1:0];
      end else begin : g_val_ext
         assign req_val_w = {{(VALUE_WIDTH-REQ_VALUE_W){1'b0}}, req_value};
      end
   endgenerate

   assign cmp_pos   = CMP_W'(req_position);
   assign cmp_cnt   = CMP_W'(cnt_ff);
   assign ptr_plus  = ptr_ff + 1'b1;
   assign ptr_minus = ptr_ff - 1'b1;
   assign count_wide = OUTC_W'(cnt_new_ff);
   assign fpos_wide  = OUTP_W'(tag_ff);

   iarr_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      cnt_in     = cnt_ff;
      cnt_new_in = cnt_new_ff;
      ptr_in     = ptr_ff;
      pend_in    = pend_ff;
      tag_in     = tag_ff;
      hit_in     = hit_ff;

      // a waiting response clears once taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_count_in  = rsp_count_ff;

      // a pending move is written in the cycle after its read
      ram_wr_en   = 1'b0;
      ram_wr_addr = tag_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = ptr_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               pos_in     = CNT_W'(req_position);
               val_in     = req_val_w;
               status_in  = ST_OK;
               cnt_new_in = cnt_ff;
               pend_in    = 1'b0;
               tag_in     = '0;
               hit_in     = 1'b0;
               state_in   = S_FINISH;
               case (req_opcode)
                  OP_INSERT: begin
                     if (cmp_pos > cmp_cnt) begin
                        status_in = ST_RANGE;
                     end else if (cmp_cnt == CMP_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        ptr_in     = cnt_ff;
                        cnt_new_in = cnt_ff + 1'b1;
                        state_in   = S_INSERT;
                     end
                  end
                  OP_REMOVE: begin
                     if (cmp_pos >= cmp_cnt) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in     = CNT_W'(req_position);
                        cnt_new_in = cnt_ff - 1'b1;
                        state_in   = S_REMOVE;
                     end
                  end
                  OP_FIND: begin
                     ptr_in   = '0;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     // unused opcode reports ok and leaves the list alone
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         S_INSERT: begin
            ram_wr_en = pend_ff;
            if (ptr_ff > pos_ff) begin
               // move entry ptr-1 up into ptr
               ram_rd_addr = ptr_minus[ADDR_W-1:0];
               pend_in     = 1'b1;
               tag_in      = ptr_ff[ADDR_W-1:0];
               ptr_in      = ptr_minus;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               // slot is open, drop the new word in
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[ADDR_W-1:0];
               ram_wr_data = val_ff;
               state_in    = S_FINISH;
            end
         end

         S_REMOVE: begin
            ram_wr_en = pend_ff;
            if (ptr_plus < cnt_ff) begin
               // move entry ptr+1 down into ptr
               ram_rd_addr = ptr_plus[ADDR_W-1:0];
               pend_in     = 1'b1;
               tag_in      = ptr_ff[ADDR_W-1:0];
               ptr_in      = ptr_plus;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_SEARCH: begin
            if (pend_ff && (ram_rd_data == val_ff)) begin
               // tag still holds the address of the matching entry
               hit_in   = 1'b1;
               pend_in  = 1'b0;
               state_in = S_FINISH;
            end else if (ptr_ff < cnt_ff) begin
               ram_rd_addr = ptr_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               tag_in      = ptr_ff[ADDR_W-1:0];
               ptr_in      = ptr_plus;
            end else begin
               pend_in  = 1'b0;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = hit_ff;
               rsp_fpos_in   = hit_ff ? fpos_wide[FPOS_W-1:0] : '0;
               rsp_count_in  = count_wide[COUNT_W-1:0];
               cnt_in        = cnt_new_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      cnt_new_ff    <= cnt_new_in;
      ptr_ff        <= ptr_in;
      tag_ff        <= tag_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;

`ifndef SYNTHESIS
   // the stored count never goes past the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(cnt_ff) <= CMP_W'(DEPTH))
      else $error("entry count above DEPTH");

   // an accepted word always starts a sequence
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

   // the ram is only written while an insert or remove is in work
   a_write_in_op: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_INSERT || state_ff == S_REMOVE))
      else $error("ram write outside insert or remove");

   // a full status leaves the list at its size
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> CMP_W'(cnt_ff) == CMP_W'(DEPTH))
      else $error("full status with list not full");

   // a match is only reported for a find that succeeded
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && hit_ff |-> op_ff == OP_FIND && status_ff == ST_OK)
      else $error("match flagged outside a find");
`endif

endmodule

`default_nettype wire
